>>> design/lpht_pkg.sv
// Shared types and constants for the linear-probe hash index table.
package lpht_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int HASH_W = 32;
  localparam int ITEM_W = 32;

  // An item index of all ones marks a slot as empty
  localparam logic [ITEM_W-1:0] EMPTY_ITEM = '1;

  typedef enum logic {
    CMD_FIND   = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_CANDIDATE = 2'd0,
    KIND_NOT_FOUND = 2'd1,
    KIND_INSERTED  = 2'd2,
    KIND_FULL      = 2'd3
  } kind_t;

  // One result beat
  typedef struct packed {
    kind_t             kind;
    logic [ITEM_W-1:0] found_index;
    logic [4:0]        slot;
    logic              last;
  } result_t;

  // Slot store read request and returned entry
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } rd_req_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [ITEM_W-1:0] item;
  } entry_t;

  // Slot store write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
  } wr_req_t;

endpackage

>>> design/lpht_if.sv
// Valid/ready channel interfaces for the hash index table.
interface lpht_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] key_hash;
  logic [31:0] item_index;

  modport source (output valid, command, key_hash, item_index, input ready);
  modport sink   (input valid, command, key_hash, item_index, output ready);
endinterface

interface lpht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] found_index;
  logic [4:0]  slot;
  logic        last;

  modport source (output valid, kind, found_index, slot, last, input ready);
  modport sink   (input valid, kind, found_index, slot, last, output ready);
endinterface

>>> design/lpht_store.sv
// Slot store: hash and item arrays with per-slot valid bits and a registered read.
module lpht_store (
  input  logic              clk,
  input  logic              rst_n,
  input  lpht_pkg::rd_req_t rd_req,
  input  lpht_pkg::wr_req_t wr_req,
  output lpht_pkg::entry_t  rd_data
);

  logic [lpht_pkg::HASH_W-1:0] hash_mem [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::ITEM_W-1:0] item_mem [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::TABLE_DEPTH-1:0] valid_r;
  lpht_pkg::entry_t rd_data_r;

  // Valid bits: a never-written slot reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_req.en) begin
      valid_r[wr_req.slot] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      hash_mem[wr_req.slot] <= wr_req.entry.hash;
      item_mem[wr_req.slot] <= wr_req.entry.item;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      if (valid_r[rd_req.slot]) begin
        rd_data_r.hash <= hash_mem[rd_req.slot];
        rd_data_r.item <= item_mem[rd_req.slot];
      end else begin
        rd_data_r.hash <= '0;
        rd_data_r.item <= lpht_pkg::EMPTY_ITEM;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/lpht_probe.sv
// Probe sequencer: walks slots one at a time through a shared compare step.
module lpht_probe (
  input  logic                        clk,
  input  logic                        rst_n,
  // Command capture
  input  logic                        cmd_take,
  input  lpht_pkg::cmd_t              cmd_in,
  input  logic [lpht_pkg::HASH_W-1:0] hash_in,
  input  logic [lpht_pkg::ITEM_W-1:0] item_in,
  output logic                        idle,
  // Slot store
  output lpht_pkg::rd_req_t           rd_req,
  output lpht_pkg::wr_req_t           wr_req,
  input  lpht_pkg::entry_t            rd_data,
  // Result handoff
  output logic                        res_valid,
  output lpht_pkg::result_t           res,
  input  logic                        res_take
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  state_t                        after_r, after_nxt;
  lpht_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [lpht_pkg::HASH_W-1:0]   hash_r, hash_nxt;
  logic [lpht_pkg::ITEM_W-1:0]   item_r, item_nxt;
  logic [lpht_pkg::SLOT_W-1:0]   start_r, start_nxt;
  logic [lpht_pkg::SLOT_W-1:0]   ptr_r, ptr_nxt;
  logic [lpht_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  lpht_pkg::result_t             pend_r, pend_nxt;
  logic [lpht_pkg::SLOT_W-1:0]   ptr_inc;
  logic [lpht_pkg::SLOT_W-1:0]   start_slot;
  logic                          slot_empty;
  logic                          hash_hit;

  // Wrap-around slot increment
  assign ptr_inc = (ptr_r == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_DEPTH - 1)) ?
                   '0 : ptr_r + 1'b1;
  assign start_slot = lpht_pkg::SLOT_W'(hash_in % lpht_pkg::TABLE_DEPTH);

  // Shared compare unit on the entry just read
  assign slot_empty = (rd_data.item == lpht_pkg::EMPTY_ITEM);
  assign hash_hit   = (rd_data.hash == hash_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    cmd_nxt   = cmd_r;
    hash_nxt  = hash_r;
    item_nxt  = item_r;
    start_nxt = start_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    rd_req    = '0;
    wr_req    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_take) begin
          cmd_nxt   = cmd_in;
          hash_nxt  = hash_in;
          item_nxt  = item_in;
          start_nxt = start_slot;
          ptr_nxt   = start_slot;
          cnt_nxt   = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (cnt_r == lpht_pkg::CNT_W'(lpht_pkg::TABLE_DEPTH)) begin
          // One full pass with no empty slot
          pend_nxt.kind        = lpht_pkg::KIND_FULL;
          pend_nxt.found_index = '0;
          pend_nxt.slot        = 5'(start_r);
          pend_nxt.last        = 1'b1;
          after_nxt            = ST_IDLE;
          state_nxt            = ST_EMIT;
        end else begin
          rd_req.en   = 1'b1;
          rd_req.slot = ptr_r;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (slot_empty) begin
          if (cmd_r == lpht_pkg::CMD_INSERT) begin
            wr_req.en         = 1'b1;
            wr_req.slot       = ptr_r;
            wr_req.entry.hash = hash_r;
            wr_req.entry.item = item_r;
            pend_nxt.kind     = lpht_pkg::KIND_INSERTED;
          end else begin
            pend_nxt.kind     = lpht_pkg::KIND_NOT_FOUND;
          end
          pend_nxt.found_index = '0;
          pend_nxt.slot        = 5'(ptr_r);
          pend_nxt.last        = 1'b1;
          after_nxt            = ST_IDLE;
          state_nxt            = ST_EMIT;
        end else begin
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r + 1'b1;
          if (cmd_r == lpht_pkg::CMD_FIND && hash_hit) begin
            pend_nxt.kind        = lpht_pkg::KIND_CANDIDATE;
            pend_nxt.found_index = rd_data.item;
            pend_nxt.slot        = 5'(ptr_r);
            pend_nxt.last        = 1'b0;
            after_nxt            = ST_RD;
            state_nxt            = ST_EMIT;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_EMIT: begin
        if (res_take) begin
          state_nxt = after_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      after_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Operation payload
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    hash_r  <= hash_nxt;
    item_r  <= item_nxt;
    start_r <= start_nxt;
    ptr_r   <= ptr_nxt;
    pend_r  <= pend_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_EMIT);
  assign res       = pend_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lpht_pkg::CNT_W'(lpht_pkg::TABLE_DEPTH))
    else $error("probe count ran past one pass");

  a_rd_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req.en |=> state_r == ST_EVAL)
    else $error("slot read not followed by evaluation");

  a_wr_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> cmd_r == lpht_pkg::CMD_INSERT && slot_empty)
    else $error("slot written outside an insert into an empty slot");

  a_last_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && res_take && pend_r.last |=> state_r == ST_IDLE)
    else $error("final result did not end the operation");

endmodule

>>> design/linear_probe_hash_index_table.sv
// Top level of the linear-probe hash index table: channels, output register.
//
// Usage:
//   in_bus  (sink)  : one beat is a command. command 0 finds candidates for
//                     key_hash, command 1 inserts (key_hash, item_index).
//   out_bus (source): result beats. A find gives one candidate beat per
//                     stored entry with the same hash, in probe order, then
//                     a not-found beat (or a table-full beat after a whole
//                     pass). An insert gives one inserted or table-full beat.
//                     last marks the final beat of each command.
// Sequencing: the command is taken in ST_IDLE; each probed slot then gets a
//   registered slot read (ST_RD), then a compare (ST_EVAL); each result beat
//   is handed to the output register from ST_EMIT, where the sequencer waits
//   while that register cannot take it.
// in_bus.ready is high only while no command is in progress. The output
//   register lets a new command be taken while the final beat still waits.
// Reset clears all slot valid bits at once, so every slot reads as empty
//   right after reset; no clearing pass is needed.
// If the receiver stalls, the sequencer holds its pending beat and waits.
module linear_probe_hash_index_table (
  input  logic        clk,
  input  logic        rst_n,
  lpht_in_if.sink     in_bus,
  lpht_out_if.source  out_bus
);

  logic               cmd_take;
  logic               idle;
  logic               res_valid;
  logic               res_take;
  lpht_pkg::result_t  res;
  lpht_pkg::rd_req_t  rd_req;
  lpht_pkg::wr_req_t  wr_req;
  lpht_pkg::entry_t   rd_data;
  logic               out_valid_r;
  lpht_pkg::result_t  out_r;

  assign in_bus.ready = idle;
  assign cmd_take     = in_bus.valid && idle;

  lpht_probe u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_take  (cmd_take),
    .cmd_in    (lpht_pkg::cmd_t'(in_bus.command)),
    .hash_in   (in_bus.key_hash),
    .item_in   (in_bus.item_index),
    .idle      (idle),
    .rd_req    (rd_req),
    .wr_req    (wr_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  lpht_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (rd_data)
  );

  // Output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.kind        = 2'(out_r.kind);
  assign out_bus.found_index = out_r.found_index;
  assign out_bus.slot        = out_r.slot;
  assign out_bus.last        = out_r.last;

endmodule

>>> tb/sv/linear_probe_hash_index_table_tb.sv
// Self-checking testbench for the linear-probe hash index table.
`timescale 1ns / 1ps

module linear_probe_hash_index_table_tb;

  // Tracks a private copy of the slot table and the result beats each
  // accepted command must produce, then checks result beats in order.
  class probe_result_scoreboard;
    logic [lpht_pkg::HASH_W-1:0] tbl_hash [lpht_pkg::TABLE_DEPTH];
    logic [lpht_pkg::ITEM_W-1:0] tbl_item [lpht_pkg::TABLE_DEPTH];
    lpht_pkg::result_t           expected_beats [$];
    int                          fail_count;
    int                          mismatch_count;

    function new();
      for (int i = 0; i < lpht_pkg::TABLE_DEPTH; i++) begin
        tbl_hash[i] = '0;
        tbl_item[i] = lpht_pkg::EMPTY_ITEM;
      end
      fail_count     = 0;
      mismatch_count = 0;
    endfunction

    function void push_beat(lpht_pkg::kind_t k, logic [lpht_pkg::ITEM_W-1:0] idx,
                            int unsigned s, logic lst);
      lpht_pkg::result_t r;
      r.kind        = k;
      r.found_index = idx;
      r.slot        = s[4:0];
      r.last        = lst;
      expected_beats.push_back(r);
    endfunction

    // Walk the probe path for one accepted command and queue its beats
    function void note_command(lpht_pkg::cmd_t cmd, logic [lpht_pkg::HASH_W-1:0] h,
                               logic [lpht_pkg::ITEM_W-1:0] idx);
      int unsigned start;
      int unsigned s;
      start = h % lpht_pkg::TABLE_DEPTH;
      s     = start;
      for (int p = 0; p < lpht_pkg::TABLE_DEPTH; p++) begin
        if (tbl_item[s] == lpht_pkg::EMPTY_ITEM) begin
          if (cmd == lpht_pkg::CMD_INSERT) begin
            tbl_hash[s] = h;
            tbl_item[s] = idx;
            push_beat(lpht_pkg::KIND_INSERTED, '0, s, 1'b1);
          end else begin
            push_beat(lpht_pkg::KIND_NOT_FOUND, '0, s, 1'b1);
          end
          return;
        end
        if (cmd == lpht_pkg::CMD_FIND && tbl_hash[s] == h)
          push_beat(lpht_pkg::KIND_CANDIDATE, tbl_item[s], s, 1'b0);
        s = (s + 1 >= lpht_pkg::TABLE_DEPTH) ? 0 : s + 1;
      end
      // one whole pass without an empty slot
      push_beat(lpht_pkg::KIND_FULL, '0, start, 1'b1);
    endfunction

    function void check_beat(lpht_pkg::result_t got);
      lpht_pkg::result_t want;
      if (expected_beats.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result beat: kind=%0d idx=%h slot=%0d last=%b",
                   $realtime, got.kind, got.found_index, got.slot, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got.kind !== want.kind || got.found_index !== want.found_index ||
          got.slot !== want.slot || got.last !== want.last) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] mismatch: exp %0d/%h/%0d/%b got %0d/%h/%0d/%b",
                   $realtime, want.kind, want.found_index, want.slot, want.last,
                   got.kind, got.found_index, got.slot, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lpht_in_if  in_ch ();
  lpht_out_if out_ch ();

  linear_probe_hash_index_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  probe_result_scoreboard sb;

  int   beats_out;
  logic quiet;      // no idling on either side while set
  logic recv_hold;  // receiver back-pressure stretch

  // Hash pool: a few values sharing start slots so probes collide
  logic [lpht_pkg::HASH_W-1:0] hash_pool [8];

  always #2 clk = ~clk;

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = lpht_pkg::CMD_FIND;
    in_ch.key_hash  = '0;
    in_ch.item_index = '0;
    out_ch.ready    = 1'b0;
    quiet           = 1'b0;
    recv_hold       = 1'b0;
    beats_out       = 0;
    sb              = new();
  end

  // Result monitor: sample accepted beats at the rising edge
  always @(posedge clk) begin
    lpht_pkg::result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind        = lpht_pkg::kind_t'(out_ch.kind);
      got.found_index = out_ch.found_index;
      got.slot        = out_ch.slot;
      got.last        = out_ch.last;
      sb.check_beat(got);
      beats_out++;
    end
  end

  // Receiver ready, updated at the falling edge
  always @(negedge clk) begin
    if (!rst_n || recv_hold)
      out_ch.ready = 1'b0;
    else if (quiet)
      out_ch.ready = 1'b1;
    else
      out_ch.ready = ($urandom_range(99) >= 14);
  end

  // One long receiver stall, so the block fills up and stops taking commands
  initial begin : receiver_hold
    wait (beats_out >= 60);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (300) @(posedge clk);
    recv_hold = 1'b0;
  end

  // Offer one command beat and wait until the block takes it
  task automatic send_cmd(lpht_pkg::cmd_t cmd, logic [lpht_pkg::HASH_W-1:0] h,
                          logic [lpht_pkg::ITEM_W-1:0] idx);
    while (!quiet && $urandom_range(99) < 14) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.command    = cmd;
    in_ch.key_hash   = h;
    in_ch.item_index = idx;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(cmd, h, idx);
    @(negedge clk);
  endtask

  function automatic logic [lpht_pkg::ITEM_W-1:0] pick_item();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return lpht_pkg::EMPTY_ITEM - 1;
    return $urandom_range(32'hFFFF_FFFE, 0);
  endfunction

  function automatic logic [lpht_pkg::HASH_W-1:0] pick_hash();
    if ($urandom_range(99) < 80) return hash_pool[3'($urandom_range(7))];
    return $urandom;
  endfunction

  // Main stimulus
  initial begin : stimulus
    logic [4:0]     base_slot [3];
    lpht_pkg::cmd_t cmd;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: edges of the hash and index fields, wrap-around, duplicates
    send_cmd(lpht_pkg::CMD_FIND,   32'h0000_0000, 32'h1234_5678);  // empty table, slot 0
    send_cmd(lpht_pkg::CMD_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFE);  // empty table, slot 31
    send_cmd(lpht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);  // slot 31
    send_cmd(lpht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFE);  // wraps to slot 0
    send_cmd(lpht_pkg::CMD_INSERT, 32'h0000_001F, 32'h0000_0005);  // other hash, same start
    send_cmd(lpht_pkg::CMD_FIND,   32'hFFFF_FFFF, 32'h0);  // two candidates across wrap
    send_cmd(lpht_pkg::CMD_FIND,   32'h0000_001F, 32'h0);
    send_cmd(lpht_pkg::CMD_FIND,   32'h0000_0000, 32'h0);  // zero hash vs occupied slots
    send_cmd(lpht_pkg::CMD_INSERT, 32'h0000_0020, 32'h0000_0007);  // duplicate pair twice
    send_cmd(lpht_pkg::CMD_INSERT, 32'h0000_0020, 32'h0000_0007);
    send_cmd(lpht_pkg::CMD_FIND,   32'h0000_0020, 32'h0);
    send_cmd(lpht_pkg::CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_cmd(lpht_pkg::CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_cmd(lpht_pkg::CMD_FIND,   32'hAAAA_AAAA, 32'h0);
    send_cmd(lpht_pkg::CMD_FIND,   32'h5555_5555, 32'h0);
    send_cmd(lpht_pkg::CMD_FIND,   32'h8000_0010, 32'h0);  // miss on an empty start slot

    // Random: mostly finds on a small hash pool, table fills as we go
    for (int i = 0; i < 3; i++) base_slot[i] = 5'($urandom_range(31));
    for (int i = 0; i < 8; i++)
      hash_pool[i] = {27'($urandom_range(32'h07FF_FFFF, 0)), base_slot[i % 3]};
    hash_pool[7] = {27'h7FF_FFFF, base_slot[0]};
    hash_pool[6] = {27'h000_0000, base_slot[1]};

    for (int n = 0; n < 300; n++) begin
      quiet = (n >= 130 && n < 180);
      cmd   = ($urandom_range(99) < 15) ? lpht_pkg::CMD_INSERT : lpht_pkg::CMD_FIND;
      send_cmd(cmd, pick_hash(), pick_item());
    end
    quiet       = 1'b0;
    in_ch.valid = 1'b0;

    // Drain the expected beats, then keep running to catch stray beats
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    if (sb.fail_count == 0 && sb.expected_beats.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Run limit
  initial begin : run_limit
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
